@@ sv/kchr_pkg.sv @@
// ----------------------------------------------------------------------------
// kchr_pkg: shared types and constants for the key chord report router
// Report layout, event mode codes, wheel deltas and chord reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package kchr_pkg;

    localparam int CHORD_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int SLOT_COUNT = 6;
    localparam int MAX_SRC    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 3;

    typedef enum logic [2:0] {
        MODE_KEY_PRESS   = 3'd0,
        MODE_KEY_RELEASE = 3'd1,
        MODE_ENC_STEP    = 3'd2,
        MODE_ENC_PRESS   = 3'd3,
        MODE_RELEASE_ALL = 3'd4
    } kchr_mode_t;

    localparam logic signed [2:0] WHEEL_PLUS  = 3'sd3;
    localparam logic signed [2:0] WHEEL_MINUS = -3'sd3;

    localparam logic [CHORD_W-1:0] CHORD_RESET [MAX_SRC] = '{
        16'd812, 16'd40, 16'd776, 16'd42, 16'd260, 16'd262, 16'd281, 16'd285
    };

    typedef struct packed {
        logic [BYTE_W-1:0]                 mods;
        logic [SLOT_COUNT-1:0][BYTE_W-1:0] usage;
    } kchr_report_t;

endpackage

`default_nettype wire

@@ sv/kchr_chord_regs.sv @@
// ----------------------------------------------------------------------------
// kchr_chord_regs: chord configuration registers
// One 16-bit chord per key source, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kchr_chord_regs #(
    parameter int NUM_SOURCES = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_valid,
    input  wire logic [kchr_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [kchr_pkg::CHORD_W-1:0]             cfg_data,
    output logic      [NUM_SOURCES-1:0][kchr_pkg::CHORD_W-1:0] chords
);
    import kchr_pkg::*;

    logic [NUM_SOURCES-1:0][CHORD_W-1:0] chord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                chord_reg[i] <= CHORD_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    chord_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign chords = chord_reg;

endmodule

`default_nettype wire

@@ sv/kchr_compose.sv @@
// ----------------------------------------------------------------------------
// kchr_compose: report composer
// ORs the modifiers of held sources and packs distinct nonzero usages in
// source order; one usage too many yields the empty report.
// ----------------------------------------------------------------------------
`default_nettype none

module kchr_compose #(
    parameter int NUM_SOURCES  = 8,
    parameter int REPORT_SLOTS = 6
) (
    input  wire logic [NUM_SOURCES-1:0]                         held,
    input  wire logic [NUM_SOURCES-1:0][kchr_pkg::CHORD_W-1:0]  chords,
    output kchr_pkg::kchr_report_t                              report
);
    import kchr_pkg::*;

    logic [BYTE_W-1:0]                 mods;
    logic [SLOT_COUNT-1:0][BYTE_W-1:0] slots;
    logic [CNT_W-1:0]                  cnt;
    logic                              ovf;
    logic                              dup;
    logic [BYTE_W-1:0]                 u;

    always_comb
    begin
        mods = '0;
        slots = '0;
        cnt = '0;
        ovf = 1'b0;
        dup = 1'b0;
        u = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (held[i])
            begin
                mods = mods | chords[i][CHORD_W-1:BYTE_W];
                u = chords[i][BYTE_W-1:0];
                dup = 1'b0;
                // empty slots hold zero and u is nonzero when it matters
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    if (slots[k] == u)
                    begin
                        dup = 1'b1;
                    end
                end
                if ((u != '0) && !dup && !ovf)
                begin
                    if (cnt >= CNT_W'(REPORT_SLOTS))
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < SLOT_COUNT; k++)
                        begin
                            if (cnt == CNT_W'(k))
                            begin
                                slots[k] = u;
                            end
                        end
                        cnt = cnt + CNT_W'(1);
                    end
                end
            end
        end
        if (ovf)
        begin
            report = '0;
        end
        else
        begin
            report.mods = mods;
            report.usage = slots;
        end
    end

endmodule

`default_nettype wire

@@ sv/key_chord_hid_report_router_unit.sv @@
// ----------------------------------------------------------------------------
// key_chord_hid_report_router_unit: key chord HID report router
// Turns key and encoder events into keyboard report and wheel delta beats.
//
//   channel | signals                                  | direction
//   evt     | evt_valid/evt_ready, mode, key_index,    | in
//           | step_value                               |
//   rpt     | rpt_valid/rpt_ready, kbd_update,         | out
//           | modifier_mask, usage_slot0..5,           |
//           | wheel_update, wheel_vertical/horizontal  |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
// One event per cycle while the report side keeps up: an event beat lands in the
// input register, is composed there and its result moves to the output register
// once the output register is empty or its report beat is taken.
// Reset releases all keys, selects the vertical axis and loads chord defaults.
// A stalled report holds the pipe; the input register keeps one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module key_chord_hid_report_router_unit #(
    parameter int NUM_SOURCES  = 8,
    parameter int REPORT_SLOTS = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              evt_valid,
    output logic                                   evt_ready,
    input  wire logic [2:0]                        mode,
    input  wire logic [3:0]                        key_index,
    input  wire logic signed [7:0]                 step_value,
    output logic                                   rpt_valid,
    input  wire logic                              rpt_ready,
    output logic                                   kbd_update,
    output logic [7:0]                             modifier_mask,
    output logic [7:0]                             usage_slot0,
    output logic [7:0]                             usage_slot1,
    output logic [7:0]                             usage_slot2,
    output logic [7:0]                             usage_slot3,
    output logic [7:0]                             usage_slot4,
    output logic [7:0]                             usage_slot5,
    output logic                                   wheel_update,
    output logic signed [2:0]                      wheel_vertical,
    output logic signed [2:0]                      wheel_horizontal,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kchr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kchr_pkg::CHORD_W-1:0]      cfg_data
);
    import kchr_pkg::*;

    // input stage
    logic             s1_valid_reg;
    logic [2:0]       s1_mode_reg;
    logic [3:0]       s1_idx_reg;
    logic signed [7:0] s1_step_reg;

    // block state
    logic [NUM_SOURCES-1:0] held_reg;
    logic [NUM_SOURCES-1:0] held_next;
    logic                   scroll_h_reg;
    logic                   scroll_h_next;

    // output stage
    logic              out_valid_reg;
    logic              kbd_chg_reg;
    logic              kbd_chg_next;
    kchr_report_t      rpt_reg;
    kchr_report_t      rpt_next;
    logic              whl_chg_reg;
    logic              whl_chg_next;
    logic signed [2:0] whl_v_reg;
    logic signed [2:0] whl_v_next;
    logic signed [2:0] whl_h_reg;
    logic signed [2:0] whl_h_next;

    logic [NUM_SOURCES-1:0][CHORD_W-1:0] chords;
    logic [NUM_SOURCES-1:0] held_after;
    kchr_report_t           rpt_before;
    kchr_report_t           rpt_after;
    logic                   press;
    logic                   advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || rpt_ready);
    assign evt_ready = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    kchr_chord_regs #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_chords (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chords    (chords)
    );

    assign press = (s1_mode_reg == MODE_KEY_PRESS);

    always_comb
    begin
        held_after = held_reg;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (s1_idx_reg == 4'(i))
            begin
                held_after[i] = press;
            end
        end
    end

    kchr_compose #(
        .NUM_SOURCES  (NUM_SOURCES),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_before (
        .held   (held_reg),
        .chords (chords),
        .report (rpt_before)
    );

    kchr_compose #(
        .NUM_SOURCES  (NUM_SOURCES),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_after (
        .held   (held_after),
        .chords (chords),
        .report (rpt_after)
    );

    always_comb
    begin
        held_next = held_reg;
        scroll_h_next = scroll_h_reg;
        kbd_chg_next = 1'b0;
        rpt_next = '0;
        whl_chg_next = 1'b0;
        whl_v_next = '0;
        whl_h_next = '0;
        unique case (s1_mode_reg)
            MODE_KEY_PRESS, MODE_KEY_RELEASE:
            begin
                // refuse a press that would blank a nonempty report
                if (!(press && (rpt_after == '0) && (rpt_before != '0)))
                begin
                    held_next = held_after;
                    if (rpt_after != rpt_before)
                    begin
                        kbd_chg_next = 1'b1;
                        rpt_next = rpt_after;
                    end
                end
            end
            MODE_ENC_STEP:
            begin
                if (s1_step_reg != '0)
                begin
                    whl_chg_next = 1'b1;
                    if (!scroll_h_reg)
                    begin
                        whl_v_next = s1_step_reg[7] ? WHEEL_PLUS : WHEEL_MINUS;
                    end
                    else
                    begin
                        whl_h_next = s1_step_reg[7] ? WHEEL_MINUS : WHEEL_PLUS;
                    end
                end
            end
            MODE_ENC_PRESS:
            begin
                scroll_h_next = !scroll_h_reg;
            end
            MODE_RELEASE_ALL:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            scroll_h_reg  <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                s1_valid_reg <= evt_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
                scroll_h_reg  <= scroll_h_next;
            end
            else if (rpt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_ready && evt_valid)
        begin
            s1_mode_reg <= mode;
            s1_idx_reg  <= key_index;
            s1_step_reg <= step_value;
        end
        if (advance)
        begin
            kbd_chg_reg <= kbd_chg_next;
            rpt_reg     <= rpt_next;
            whl_chg_reg <= whl_chg_next;
            whl_v_reg   <= whl_v_next;
            whl_h_reg   <= whl_h_next;
        end
    end

    assign rpt_valid        = out_valid_reg;
    assign kbd_update       = kbd_chg_reg;
    assign modifier_mask    = rpt_reg.mods;
    assign usage_slot0      = rpt_reg.usage[0];
    assign usage_slot1      = rpt_reg.usage[1];
    assign usage_slot2      = rpt_reg.usage[2];
    assign usage_slot3      = rpt_reg.usage[3];
    assign usage_slot4      = rpt_reg.usage[4];
    assign usage_slot5      = rpt_reg.usage[5];
    assign wheel_update     = whl_chg_reg;
    assign wheel_vertical   = whl_v_reg;
    assign wheel_horizontal = whl_h_reg;

endmodule

`default_nettype wire

@@ tb/kchr_report_checker.sv @@
// ----------------------------------------------------------------------------
// kchr_report_checker: report predictor and scoreboard for the chord router
// Watches the event, report and chord write channels, keeps its own copy of
// the chords, the held keys and the scroll axis, predicts one report beat per
// event beat and compares every report beat field by field, in order.
// ----------------------------------------------------------------------------

module kchr_report_checker #(
    parameter int NUM_SOURCES  = 8,
    parameter int REPORT_SLOTS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              evt_valid,
    input  logic                              evt_ready,
    input  logic [2:0]                        mode,
    input  logic [3:0]                        key_index,
    input  logic signed [7:0]                 step_value,
    input  logic                              rpt_valid,
    input  logic                              rpt_ready,
    input  logic                              kbd_update,
    input  logic [7:0]                        modifier_mask,
    input  logic [7:0]                        usage_slot0,
    input  logic [7:0]                        usage_slot1,
    input  logic [7:0]                        usage_slot2,
    input  logic [7:0]                        usage_slot3,
    input  logic [7:0]                        usage_slot4,
    input  logic [7:0]                        usage_slot5,
    input  logic                              wheel_update,
    input  logic signed [2:0]                 wheel_vertical,
    input  logic signed [2:0]                 wheel_horizontal,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [kchr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kchr_pkg::CHORD_W-1:0]      cfg_data,
    output int                                fail_count,
    output int                                outstanding
);

    import kchr_pkg::*;

    typedef struct packed {
        logic               kb_changed;
        kchr_report_t       kb;
        logic               wh_changed;
        logic signed [2:0]  vert;
        logic signed [2:0]  horz;
    } report_beat_t;

    logic [CHORD_W-1:0]  chord_q [MAX_SRC];
    logic [MAX_SRC-1:0]  held;
    logic                axis_horz;
    report_beat_t        expected_reports [$];

    initial fail_count = 0;

    // usage[k] holds slot k; a usage past the last slot empties the report
    function automatic kchr_report_t compose_keyboard(input logic [MAX_SRC-1:0] keys);
        kchr_report_t r;
        int           n;
        logic [7:0]   u;
        bit           dup;
        r = '0;
        n = 0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (keys[i])
            begin
                r.mods = r.mods | chord_q[i][15:8];
                u = chord_q[i][7:0];
                dup = 1'b0;
                for (int k = 0; k < n; k++)
                    if (r.usage[k] == u) dup = 1'b1;
                if (u != 8'h00 && !dup)
                begin
                    if (n >= REPORT_SLOTS)
                        return '0;
                    r.usage[n] = u;
                    n++;
                end
            end
        end
        return r;
    endfunction

    function automatic report_beat_t apply_event(input logic [2:0] m,
                                                 input logic [3:0] idx,
                                                 input logic signed [7:0] stp);
        report_beat_t       b;
        kchr_report_t       prev_r;
        kchr_report_t       next_r;
        logic [MAX_SRC-1:0] next_held;
        logic               press;
        b = '0;
        case (m)
            MODE_KEY_PRESS, MODE_KEY_RELEASE:
            begin
                press = (m == MODE_KEY_PRESS);
                if (idx < NUM_SOURCES && held[idx] != press)
                begin
                    next_held = held;
                    next_held[idx] = press;
                    prev_r = compose_keyboard(held);
                    next_r = compose_keyboard(next_held);
                    // refuse a press that would wipe out a nonempty report
                    if (!(press && next_r == '0 && prev_r != '0))
                    begin
                        held = next_held;
                        if (next_r != prev_r)
                        begin
                            b.kb_changed = 1'b1;
                            b.kb = next_r;
                        end
                    end
                end
            end
            MODE_ENC_STEP:
            begin
                if (stp != 0)
                begin
                    b.wh_changed = 1'b1;
                    if (axis_horz)
                        b.horz = (stp < 0) ? WHEEL_MINUS : WHEEL_PLUS;
                    else
                        b.vert = (stp < 0) ? WHEEL_PLUS : WHEEL_MINUS;
                end
            end
            MODE_ENC_PRESS:   axis_horz = !axis_horz;
            MODE_RELEASE_ALL: held = '0;
            default: ;
        endcase
        return b;
    endfunction

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        report_beat_t want;
        logic [7:0]   got_slot [SLOT_COUNT];
        if (!rst_n)
        begin
            chord_q = CHORD_RESET;
            held = '0;
            axis_horz = 1'b0;
            expected_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rpt_valid && rpt_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report beat arrived with no report outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    got_slot = '{usage_slot0, usage_slot1, usage_slot2,
                                 usage_slot3, usage_slot4, usage_slot5};
                    check_field("kbd_update", want.kb_changed, kbd_update);
                    check_field("modifier_mask", want.kb.mods, modifier_mask);
                    for (int k = 0; k < SLOT_COUNT; k++)
                        check_field($sformatf("usage_slot%0d", k), want.kb.usage[k],
                                    got_slot[k]);
                    check_field("wheel_update", want.wh_changed, wheel_update);
                    check_field("wheel_vertical", want.vert, wheel_vertical);
                    check_field("wheel_horizontal", want.horz, wheel_horizontal);
                end
            end
            if (cfg_valid && cfg_ready)
                chord_q[cfg_index] = cfg_data;
            if (evt_valid && evt_ready)
                expected_reports.push_back(apply_event(mode, key_index, step_value));
            outstanding <= expected_reports.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the key chord HID report router
// Drives a directed burst with the default chords, then phases of random key
// and encoder events under several chord settings, with random stalls on both
// channels, one long report hold-off and drained pauses between phases.
// ----------------------------------------------------------------------------

module testbench;

    import kchr_pkg::*;

    localparam int NUM_SOURCES      = 8;
    localparam int REPORT_SLOTS     = 6;
    localparam int PIPE_LATENCY     = 2;
    localparam int PHASES           = 10;
    localparam int EVENTS_PER_PHASE = 152;
    localparam int LONG_HOLD_AFTER  = 600;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT   = 500;

    typedef enum int {
        CH_ALL_ZERO,
        CH_ALL_ONES,
        CH_DISTINCT,
        CH_POOLED,
        CH_RANDOM
    } chord_set_t;

    logic                     clk;
    logic                     rst_n;
    logic                     evt_valid;
    logic                     evt_ready;
    logic [2:0]               mode;
    logic [3:0]               key_index;
    logic signed [7:0]        step_value;
    logic                     rpt_valid;
    logic                     rpt_ready;
    logic                     kbd_update;
    logic [7:0]               modifier_mask;
    logic [7:0]               usage_slot0;
    logic [7:0]               usage_slot1;
    logic [7:0]               usage_slot2;
    logic [7:0]               usage_slot3;
    logic [7:0]               usage_slot4;
    logic [7:0]               usage_slot5;
    logic                     wheel_update;
    logic signed [2:0]        wheel_vertical;
    logic signed [2:0]        wheel_horizontal;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CHORD_W-1:0]       cfg_data;

    int fail_count;
    int outstanding;
    int idle_pct;
    int quiet_cycles;

    key_chord_hid_report_router_unit #(
        .NUM_SOURCES  (NUM_SOURCES),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_ready        (evt_ready),
        .mode             (mode),
        .key_index        (key_index),
        .step_value       (step_value),
        .rpt_valid        (rpt_valid),
        .rpt_ready        (rpt_ready),
        .kbd_update       (kbd_update),
        .modifier_mask    (modifier_mask),
        .usage_slot0      (usage_slot0),
        .usage_slot1      (usage_slot1),
        .usage_slot2      (usage_slot2),
        .usage_slot3      (usage_slot3),
        .usage_slot4      (usage_slot4),
        .usage_slot5      (usage_slot5),
        .wheel_update     (wheel_update),
        .wheel_vertical   (wheel_vertical),
        .wheel_horizontal (wheel_horizontal),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    kchr_report_checker #(
        .NUM_SOURCES  (NUM_SOURCES),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_ready        (evt_ready),
        .mode             (mode),
        .key_index        (key_index),
        .step_value       (step_value),
        .rpt_valid        (rpt_valid),
        .rpt_ready        (rpt_ready),
        .kbd_update       (kbd_update),
        .modifier_mask    (modifier_mask),
        .usage_slot0      (usage_slot0),
        .usage_slot1      (usage_slot1),
        .usage_slot2      (usage_slot2),
        .usage_slot3      (usage_slot3),
        .usage_slot4      (usage_slot4),
        .usage_slot5      (usage_slot5),
        .wheel_update     (wheel_update),
        .wheel_vertical   (wheel_vertical),
        .wheel_horizontal (wheel_horizontal),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    always #5 clk = ~clk;

    // Hold the event beat until it is taken; leave valid up for the caller.
    task automatic send_event(input logic [2:0] m, input logic [3:0] idx,
                              input logic signed [7:0] stp);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 10);
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid  <= 1'b1;
        mode       <= m;
        key_index  <= idx;
        step_value <= stp;
        @(posedge clk);
        while (!evt_ready) @(posedge clk);
    endtask

    // Stop offering events and wait until every report has come back.
    task automatic drain_reports();
        evt_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic program_chords(input chord_set_t kind);
        logic [CHORD_W-1:0] value;
        logic [7:0]         base;
        base = 8'($urandom_range(1, 240));
        for (int i = 0; i < MAX_SRC; i++)
        begin
            case (kind)
                CH_ALL_ZERO: value = '0;
                CH_ALL_ONES: value = '1;
                CH_DISTINCT: value = {8'($urandom), base + 8'(i)};
                CH_POOLED:
                begin
                    value[15:8] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
                    value[7:0]  = ($urandom_range(0, 3) == 0) ? 8'h00
                                                               : 8'($urandom_range(4, 10));
                end
                default: value = 16'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_event();
        int                pick;
        logic [2:0]        m;
        logic [3:0]        idx;
        logic signed [7:0] stp;
        pick = $urandom_range(0, 99);
        idx  = 4'($urandom_range(0, NUM_SOURCES - 1));
        stp  = 8'($urandom);
        if (pick < 40)
        begin
            m = MODE_KEY_PRESS;
        end
        else if (pick < 68)
        begin
            m = MODE_KEY_RELEASE;
        end
        else if (pick < 80)
        begin
            m = MODE_ENC_STEP;
            if ($urandom_range(0, 7) == 0) stp = '0;
        end
        else if (pick < 85)
        begin
            m = MODE_ENC_PRESS;
            idx = 4'($urandom);
        end
        else if (pick < 88)
        begin
            m = MODE_RELEASE_ALL;
            idx = 4'($urandom);
        end
        else if (pick < 94)
        begin
            // unused mode codes
            m = 3'($urandom_range(5, 7));
            idx = 4'($urandom);
        end
        else
        begin
            // key event outside the source range
            m = $urandom_range(0, 1) ? MODE_KEY_PRESS : MODE_KEY_RELEASE;
            idx = 4'($urandom_range(NUM_SOURCES, 15));
        end
        send_event(m, idx, stp);
    endtask

    // Report side: random stall bursts, plus one long hold-off that backs up the pipe.
    initial
    begin : report_sink
        int beats;
        int gap;
        bit held_off;
        beats = 0;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rpt_valid && rpt_ready) beats++;
            if (!held_off && beats >= LONG_HOLD_AFTER)
            begin
                held_off = 1'b1;
                rpt_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                rpt_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                gap = $urandom_range(1, 10);
                rpt_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                rpt_ready <= 1'b1;
            end
            else
            begin
                rpt_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (rpt_valid && rpt_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        chord_set_t kind;
        clk        = 1'b0;
        rst_n      = 1'b0;
        evt_valid  = 1'b0;
        mode       = '0;
        key_index  = '0;
        step_value = '0;
        rpt_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_pct   = 20;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default chords: eight distinct usages, so the seventh held key overflows
        send_event(MODE_KEY_RELEASE, 4'd0, 8'sd0);
        send_event(MODE_KEY_PRESS, 4'd0, 8'sd0);
        send_event(MODE_KEY_PRESS, 4'd0, -8'sd1);
        send_event(MODE_KEY_PRESS, 4'd15, 8'sd0);
        send_event(MODE_KEY_RELEASE, 4'd8, 8'sd0);
        for (int i = 1; i < 6; i++)
            send_event(MODE_KEY_PRESS, 4'(i), 8'sd0);
        send_event(MODE_KEY_PRESS, 4'd6, 8'sd0);
        send_event(MODE_KEY_PRESS, 4'd7, 8'sd0);
        send_event(MODE_KEY_RELEASE, 4'd2, 8'sd0);
        send_event(MODE_KEY_PRESS, 4'd7, 8'sd0);
        send_event(MODE_ENC_STEP, 4'd0, 8'sd127);
        send_event(MODE_ENC_STEP, 4'd15, -8'sd128);
        send_event(MODE_ENC_STEP, 4'd0, 8'sd0);
        send_event(MODE_ENC_PRESS, 4'd0, 8'sd0);
        send_event(MODE_ENC_STEP, 4'd0, 8'sd1);
        send_event(MODE_ENC_STEP, 4'd0, -8'sd1);
        send_event(MODE_ENC_STEP, 4'd0, 8'sd0);
        send_event(MODE_ENC_PRESS, 4'd0, 8'sd0);
        send_event(3'd5, 4'd3, 8'sd5);
        send_event(3'd6, 4'd7, -8'sd5);
        send_event(3'd7, 4'd12, 8'sd127);
        send_event(MODE_RELEASE_ALL, 4'd0, 8'sd0);
        send_event(MODE_KEY_RELEASE, 4'd0, 8'sd0);
        drain_reports();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       kind = CH_DISTINCT;
                1:       kind = CH_ALL_ZERO;
                2:       kind = CH_POOLED;
                3:       kind = CH_ALL_ONES;
                4:       kind = CH_RANDOM;
                default: kind = chord_set_t'($urandom_range(CH_DISTINCT, CH_RANDOM));
            endcase
            program_chords(kind);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (p == PHASES - 1) idle_pct = 0;
            for (int n = 0; n < EVENTS_PER_PHASE; n++)
                send_random_event();
            drain_reports();
        end

        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
